// ----- hw/rtl/bmmn_pkg.sv -----
// Package for the blended multiply / max-min neuron unit.
// Field widths, reset constants, controller states and command/status structs.
// No dependencies.
package bmmn_pkg;

  localparam int MAX_INPUTS = 1024;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = 42;
  localparam int IDX_W      = $clog2(MAX_INPUTS);
  localparam int BLEND_W    = 16;
  localparam int FRAC_W     = 15;
  localparam int ACC_W      = 60;
  localparam int HALF_W     = 21;            // sum split for the shared multiplier
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = BLEND_W + 1;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  localparam logic [BLEND_W-1:0] Q_ONE   = BLEND_W'(2 ** FRAC_W);
  localparam logic [IDX_W-1:0]   IDX_MAX = IDX_W'(MAX_INPUTS - 1);

  // most negative / most positive product
  localparam logic signed [PROD_W-1:0] MAX_RST =
    PROD_W'(-(2 ** (DATA_W - 1)) * (2 ** (DATA_W - 1) - 1));
  localparam logic signed [PROD_W-1:0] MIN_RST = PROD_W'(2 ** (2 * DATA_W - 2));

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MSEL_LO,
    MSEL_HI,
    MSEL_MM
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    mul_sel_t mul_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/bmmn_ctrl.sv -----
// Controller FSM for the blended neuron unit.
// Sequences accumulation, the three-step blend multiply and the result load.
// Depends on bmmn_pkg.
module bmmn_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  bmmn_pkg::status_t status,
  output bmmn_pkg::cmd_t    cmd
);
  import bmmn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.mul_sel  = MSEL_LO;
    cmd.acc_clr  = 1'b0;
    cmd.acc_add  = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last product is folded into the run state here
      ST_DRAIN: begin
        state_nxt = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.mul_sel = MSEL_LO;
        cmd.acc_clr = 1'b1;
        state_nxt   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_sel = MSEL_HI;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_sel = MSEL_MM;
        cmd.acc_add = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bmmn_datapath.sv -----
// Datapath for the blended neuron unit: product stage, run state (max, min,
// sum, positions), shared blend multiplier, accumulator and output register.
// Depends on bmmn_pkg.
module bmmn_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bmmn_pkg::cmd_t                    cmd,
  output bmmn_pkg::status_t                 status,
  input  logic [bmmn_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              cfg_valid,
  input  logic [bmmn_pkg::BLEND_W-1:0]      cfg_data,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [bmmn_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import bmmn_pkg::*;

  logic signed [DATA_W-1:0]  act, wgt;
  logic signed [PROD_W-1:0]  p_r;
  logic                      p_valid_r;
  logic [BLEND_W-1:0]        blend_r;

  logic signed [PROD_W-1:0]  max_r, min_r;
  logic [IDX_W-1:0]          max_pos_r, min_pos_r, cnt_r;
  logic signed [SUM_W-1:0]   sum_r, sum_sat;
  logic signed [SUM_W:0]     sum_ext;

  logic [BLEND_W-1:0]        beta, nbeta;
  logic signed [PROD_W:0]    mm_sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [ACC_W-1:0]   mprod_r, mprod_nxt, acc_r, q;
  logic signed [SUM_W-1:0]   q_sat;

  logic                      out_tvalid_r;
  logic signed [SUM_W-1:0]   out_val_r;
  logic [IDX_W-1:0]          out_max_r, out_min_r;

  assign act = in_tdata[DATA_W-1:0];
  assign wgt = in_tdata[2*DATA_W-1:DATA_W];

  // saturating running sum
  assign sum_ext = {sum_r[SUM_W-1], sum_r} + (SUM_W + 1)'(p_r);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // blend weights, beta clipped to one
  assign beta   = (blend_r > Q_ONE) ? Q_ONE : blend_r;
  assign nbeta  = Q_ONE - beta;
  assign mm_sum = {max_r[PROD_W-1], max_r} + {min_r[PROD_W-1], min_r};

  always_comb begin
    case (cmd.mul_sel)
      MSEL_LO: begin
        mul_a = MUL_A_W'({1'b0, sum_r[HALF_W-1:0]});
        mul_b = {1'b0, nbeta};
      end
      MSEL_HI: begin
        mul_a = MUL_A_W'($signed(sum_r[SUM_W-1:HALF_W]));
        mul_b = {1'b0, nbeta};
      end
      MSEL_MM: begin
        mul_a = MUL_A_W'(mm_sum);
        mul_b = {1'b0, beta};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mprod_nxt = ACC_W'(mul_p);
    if (cmd.mul_sel == MSEL_HI) begin
      mprod_nxt = mprod_nxt <<< HALF_W;
    end
  end

  // floor division by 2^15, then clamp to the result width
  assign q = acc_r >>> FRAC_W;
  always_comb begin
    if (q > ACC_W'(SUM_MAX)) begin
      q_sat = SUM_MAX;
    end else if (q < ACC_W'(SUM_MIN)) begin
      q_sat = SUM_MIN;
    end else begin
      q_sat = q[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      blend_r      <= Q_ONE;
      max_r        <= MAX_RST;
      min_r        <= MIN_RST;
      max_pos_r    <= '0;
      min_pos_r    <= '0;
      cnt_r        <= '0;
      sum_r        <= '0;
    end else begin
      p_valid_r <= cmd.accept;
      if (cfg_valid) begin
        blend_r <= cfg_data;
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cmd.out_load) begin
        max_r     <= MAX_RST;
        min_r     <= MIN_RST;
        max_pos_r <= '0;
        min_pos_r <= '0;
        cnt_r     <= '0;
        sum_r     <= '0;
      end else if (p_valid_r) begin
        // strict compares keep the earliest position on ties
        if (p_r > max_r) begin
          max_r     <= p_r;
          max_pos_r <= cnt_r;
        end
        if (p_r < min_r) begin
          min_r     <= p_r;
          min_pos_r <= cnt_r;
        end
        sum_r <= sum_sat;
        if (cnt_r != IDX_MAX) begin
          cnt_r <= cnt_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r <= act * wgt;
    end
    mprod_r <= mprod_nxt;
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + mprod_r;
    end
    if (cmd.out_load) begin
      out_val_r <= q_sat;
      out_max_r <= max_pos_r;
      out_min_r <= min_pos_r;
    end
  end

  assign status.out_free = !out_tvalid_r || out_tready;
  assign out_tvalid      = out_tvalid_r;
  assign out_tdata       = OUT_DATA_W'({out_min_r, out_max_r, out_val_r});

endmodule

// ----- hw/rtl/blended_mac_max_min_neuron_unit.sv -----
// Blended multiply / max-min neuron: top level, controller plus datapath.
// Throughput: one item per cycle within a vector; after the last item, input is held off
// through the drain state, three passes through the shared 34x17 blend multiplier,
// the final add and the result load, which waits until the output is free.
// The result is registered in the output register on that load and is then valid.
// Reset (rst_n low, synchronous) clears the run state and sets blend_factor to one.
module blended_mac_max_min_neuron_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bmmn_pkg::IN_DATA_W-1:0]    in_tdata,   // activation, weight
  input  logic                              in_tlast,   // last_element
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmmn_pkg::BLEND_W-1:0]      cfg_data,   // blend_factor
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bmmn_pkg::OUT_DATA_W-1:0]   out_tdata   // neuron_out, max_index, min_index
);
  import bmmn_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  bmmn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bmmn_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hw/rtl/bmmn_checker.sv -----
// Port-level checks for the blended neuron unit, bound to the top level.
// Depends on bmmn_pkg.
module bmmn_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tlast,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bmmn_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import bmmn_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no new item while a finished vector is being blended
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready ##1 !in_tready)
    else $error("item accepted during blend");

  // result never shows right after the last item
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast && !out_tvalid |=> !out_tvalid)
    else $error("result too early");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:SUM_W+2*IDX_W] == '0)
    else $error("nonzero padding");

endmodule

bind blended_mac_max_min_neuron_unit bmmn_checker u_bmmn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
